// ===== src/lzss_window_decoder_defines.svh =====
// Assertion helpers for the window decoder
`ifndef LZSS_WINDOW_DECODER_DEFINES_SVH
`define LZSS_WINDOW_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define LZWD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lzwd: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define LZWD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lzwd: next-cycle check failed");

`endif

// ===== src/lzwd_pkg.sv =====
package lzwd_pkg;

    localparam int BYTE_W         = 8;
    localparam int OFFSET_W       = 12;
    localparam int LEN_W          = 5;
    localparam int COUNT_W        = 32;
    localparam int MIN_MATCH      = 3;
    localparam int FLAGS_PER_BYTE = 8;
    localparam int FLAG_CNT_W     = 4;

    // Sequencer states
    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RD    = 2'd2;
    localparam logic [1:0] ST_WR    = 2'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              source_empty;
    } lzwd_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              last_of_run;
        logic              stream_done;
        logic              status;
    } lzwd_out_t;

endpackage

// ===== src/lzss_window_decoder.sv =====
// A source-empty word, or a literal within the stream length, yields its result in the cycle after acceptance.
// Flag and first match bytes are absorbed with no result.
// A match copies one byte per pass: a window read, then write and emit, which waits
// while the output slot is full; the history window has a single registered read port.
// Reset (synchronous, aresetn low) clears control state, then a clearing pass zeroes
// every window entry; no input word is taken until it ends.
`include "lzss_window_decoder_defines.svh"

module lzss_window_decoder #(
    parameter int WINDOW_SIZE = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [lzwd_pkg::COUNT_W-1:0]    cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  lzwd_pkg::lzwd_in_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output lzwd_pkg::lzwd_out_t             m_data
);

    localparam int AW = $clog2(WINDOW_SIZE);

    logic [1:0]                        state_reg, state_next;
    logic [AW-1:0]                     wp_reg, wp_next;
    logic [lzwd_pkg::COUNT_W-1:0]      bytes_reg, bytes_next;
    logic [lzwd_pkg::COUNT_W-1:0]      total_reg;
    logic [lzwd_pkg::BYTE_W-1:0]       shift_reg, shift_next;
    logic [lzwd_pkg::FLAG_CNT_W-1:0]   rem_reg, rem_next;
    logic                              phase_reg, phase_next;
    logic [lzwd_pkg::BYTE_W-1:0]       mfb_reg, mfb_next;
    logic [lzwd_pkg::OFFSET_W-1:0]     offm1_reg, offm1_next;
    logic [lzwd_pkg::LEN_W-1:0]        cnt_reg, cnt_next;
    logic                              m_valid_reg, m_valid_next;
    lzwd_pkg::lzwd_out_t               m_data_reg, m_data_next;

    logic [lzwd_pkg::BYTE_W-1:0]       mem [WINDOW_SIZE];
    logic [lzwd_pkg::BYTE_W-1:0]       rdata_reg;
    logic                              mem_we, mem_re;
    logic [lzwd_pkg::BYTE_W-1:0]       mem_wdata;
    logic [AW-1:0]                     mem_raddr;

    logic out_free, accept, complete, done_next, last_copy;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == lzwd_pkg::ST_IDLE) && out_free;
    assign accept    = s_valid && s_ready;
    assign complete  = bytes_reg >= total_reg;
    assign done_next = (bytes_reg + 32'd1) >= total_reg;
    assign last_copy = (cnt_reg == lzwd_pkg::LEN_W'(1)) || done_next;
    assign mem_raddr = wp_reg - offm1_reg[AW-1:0] - AW'(1);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Sequencer and datapath next values
    always_comb begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        bytes_next   = bytes_reg;
        shift_next   = shift_reg;
        rem_next     = rem_reg;
        phase_next   = phase_reg;
        mfb_next     = mfb_reg;
        offm1_next   = offm1_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_wdata    = '0;

        unique case (state_reg)
            lzwd_pkg::ST_CLEAR: begin
                // Zero the window one entry a cycle
                mem_we  = 1'b1;
                wp_next = wp_reg + AW'(1);
                if (wp_reg == AW'(WINDOW_SIZE - 1)) begin
                    state_next = lzwd_pkg::ST_IDLE;
                end
            end
            lzwd_pkg::ST_IDLE: begin
                if (accept) begin
                    priority if (s_data.source_empty) begin
                        m_valid_next = 1'b1;
                        m_data_next  = '{out_byte: '0, byte_valid: 1'b0, last_of_run: 1'b1,
                                         stream_done: complete, status: !complete};
                    end else if (complete) begin
                        // Drop bytes past the end of the stream
                    end else if (phase_reg) begin
                        // Second match byte: start the copy
                        phase_next = 1'b0;
                        offm1_next = {mfb_reg[7:4], s_data.in_byte};
                        cnt_next   = {1'b0, mfb_reg[3:0]} + lzwd_pkg::LEN_W'(lzwd_pkg::MIN_MATCH);
                        state_next = lzwd_pkg::ST_RD;
                    end else if (rem_reg == '0) begin
                        // New flag byte
                        shift_next = s_data.in_byte;
                        rem_next   = lzwd_pkg::FLAG_CNT_W'(lzwd_pkg::FLAGS_PER_BYTE);
                    end else begin
                        shift_next = {shift_reg[6:0], 1'b0};
                        rem_next   = rem_reg - lzwd_pkg::FLAG_CNT_W'(1);
                        if (shift_reg[7]) begin
                            mfb_next   = s_data.in_byte;
                            phase_next = 1'b1;
                        end else begin
                            // Literal: emit and record
                            mem_we       = 1'b1;
                            mem_wdata    = s_data.in_byte;
                            wp_next      = wp_reg + AW'(1);
                            bytes_next   = bytes_reg + 32'd1;
                            m_valid_next = 1'b1;
                            m_data_next  = '{out_byte: s_data.in_byte, byte_valid: 1'b1,
                                             last_of_run: 1'b1, stream_done: done_next,
                                             status: 1'b0};
                        end
                    end
                end
            end
            lzwd_pkg::ST_RD: begin
                // Fetch the source byte of the copy
                mem_re     = 1'b1;
                state_next = lzwd_pkg::ST_WR;
            end
            lzwd_pkg::ST_WR: begin
                // Hold until the output slot frees, then emit and write back
                if (out_free) begin
                    mem_we       = 1'b1;
                    mem_wdata    = rdata_reg;
                    wp_next      = wp_reg + AW'(1);
                    bytes_next   = bytes_reg + 32'd1;
                    cnt_next     = cnt_reg - lzwd_pkg::LEN_W'(1);
                    m_valid_next = 1'b1;
                    m_data_next  = '{out_byte: rdata_reg, byte_valid: 1'b1,
                                     last_of_run: last_copy, stream_done: done_next,
                                     status: 1'b0};
                    state_next   = last_copy ? lzwd_pkg::ST_IDLE : lzwd_pkg::ST_RD;
                end
            end
            default: state_next = lzwd_pkg::ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lzwd_pkg::ST_CLEAR;
            wp_reg      <= '0;
            bytes_reg   <= '0;
            total_reg   <= '0;
            shift_reg   <= '0;
            rem_reg     <= '0;
            phase_reg   <= 1'b0;
            mfb_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            bytes_reg   <= bytes_next;
            shift_reg   <= shift_next;
            rem_reg     <= rem_next;
            phase_reg   <= phase_next;
            mfb_reg     <= mfb_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                total_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        offm1_reg  <= offm1_next;
        cnt_reg    <= cnt_next;
        m_data_reg <= m_data_next;
    end

    // History window: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wp_reg] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    `LZWD_ASSERT_NOW(a_copy_cnt_live, aclk, aresetn,
        (state_reg == lzwd_pkg::ST_RD || state_reg == lzwd_pkg::ST_WR), (cnt_reg != '0))
    `LZWD_ASSERT_NEXT(a_read_then_write, aclk, aresetn,
        (state_reg == lzwd_pkg::ST_RD), (state_reg == lzwd_pkg::ST_WR))
    `LZWD_ASSERT_NOW(a_quiet_in_clear, aclk, aresetn,
        (state_reg == lzwd_pkg::ST_CLEAR), (!m_valid_reg && !s_ready))

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int  WIN         = 4096;
    localparam int  SETTLE      = 40;
    localparam int  CYCLE_LIMIT = 500000;
    localparam int  MAX_GAP     = 50;
    localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF;

    // Token phase of the decoder
    localparam logic [1:0] PH_TOKEN  = 2'd0;
    localparam logic [1:0] PH_MATCH2 = 2'd1;

    // Idling modes
    localparam int IDLE_NONE   = 0;
    localparam int IDLE_SEND   = 1;
    localparam int IDLE_RECV   = 2;
    localparam int IDLE_BOTH   = 3;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           cfg_wr_en;
    logic [lzwd_pkg::COUNT_W-1:0]   cfg_wr_data;
    logic                           s_valid;
    logic                           s_ready;
    lzwd_pkg::lzwd_in_t             s_data;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    lzwd_pkg::lzwd_out_t            m_data;

    // Decoder mirror
    logic [7:0]           win_mem [0:WIN-1];
    logic [11:0]          wr_pos;
    logic [31:0]          produced;
    logic [31:0]          total_len;
    logic [7:0]           flag_bits;
    logic [3:0]           flags_left;
    logic [1:0]           tok_phase;
    logic [7:0]           first_byte;

    lzwd_pkg::lzwd_out_t  decoded_q [$];
    lzwd_pkg::lzwd_out_t  want;
    int                   fails = 0;
    int                   cycle_cnt = 0;
    int                   send_pct = 0;
    int                   recv_pct = 0;
    int                   hold_left = 0;

    lzss_window_decoder #(
        .WINDOW_SIZE (WIN)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: a long hold-off while one is pending, random stalls otherwise
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_pct);
        end
    end

    // Write one byte into the mirrored window and form its result word
    function lzwd_pkg::lzwd_out_t emit_byte(input logic [7:0] b);
        lzwd_pkg::lzwd_out_t r;
        r = '0;
        win_mem[wr_pos] = b;
        wr_pos = wr_pos + 12'd1;
        produced = produced + 32'd1;
        r.out_byte = b;
        r.byte_valid = 1'b1;
        r.stream_done = (produced >= total_len);
        return r;
    endfunction

    // Advance the mirror by one accepted word and queue the words it causes
    task decode_word(input lzwd_pkg::lzwd_in_t w);
        lzwd_pkg::lzwd_out_t r;
        lzwd_pkg::lzwd_out_t pend;
        logic [12:0] off;
        logic [4:0]  len;
        logic [11:0] idx;
        logic        take_copy;
        int          n;
        int          k;
        n = 0;
        r = '0;
        pend = '0;
        if (w.source_empty) begin
            r.last_of_run = 1'b1;
            r.stream_done = (produced >= total_len);
            r.status = !(produced >= total_len);
            decoded_q.push_back(r);
        end else if (produced < total_len) begin
            if (tok_phase == PH_MATCH2) begin
                off = {1'b0, first_byte[7:4], w.in_byte} + 13'd1;
                len = {1'b0, first_byte[3:0]} + 5'd3;
                tok_phase = PH_TOKEN;
                // Copy one byte at a time so overlapping copies see fresh bytes
                for (k = 0; k < len && produced < total_len; k++) begin
                    if (n > 0)
                        decoded_q.push_back(pend);
                    idx = wr_pos - off[11:0];
                    pend = emit_byte(win_mem[idx]);
                    n++;
                end
            end else begin
                tok_phase = PH_TOKEN;
                if (flags_left == 4'd0) begin
                    flag_bits = w.in_byte;
                    flags_left = 4'd8;
                end else begin
                    take_copy = flag_bits[7];
                    flag_bits = {flag_bits[6:0], 1'b0};
                    flags_left = flags_left - 4'd1;
                    if (take_copy) begin
                        first_byte = w.in_byte;
                        tok_phase = PH_MATCH2;
                    end else begin
                        pend = emit_byte(w.in_byte);
                        n++;
                    end
                end
            end
            if (n > 0) begin
                pend.last_of_run = 1'b1;
                decoded_q.push_back(pend);
            end
        end
    endtask

    // Pick the next word from the decoder's parse state, with some noise
    function lzwd_pkg::lzwd_in_t next_word(input int noise_pct);
        lzwd_pkg::lzwd_in_t w;
        w = '0;
        if ($urandom_range(99) < noise_pct) begin
            w.in_byte = 8'($urandom_range(255));
            w.source_empty = ($urandom_range(1) == 0);
        end else if (flags_left == 4'd0 || tok_phase == PH_MATCH2) begin
            w.in_byte = 8'($urandom_range(255));
        end else if (flag_bits[7]) begin
            // Mostly near offsets so copies read recent bytes
            w.in_byte[3:0] = 4'($urandom_range(15));
            w.in_byte[7:4] = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd0;
        end else begin
            w.in_byte = 8'($urandom_range(255));
        end
        return w;
    endfunction

    // Offer one word and hold it until accepted
    task send_word(input lzwd_pkg::lzwd_in_t w);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_pct && gap < MAX_GAP)
            gap++;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        decode_word(w);
    endtask

    function lzwd_pkg::lzwd_in_t mk_word(input logic [7:0] b, input logic empty);
        lzwd_pkg::lzwd_in_t w;
        w.in_byte = b;
        w.source_empty = empty;
        return w;
    endfunction

    // Withdraw the last word, then wait for every expected word to arrive
    task drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Change the length only with the decoder idle
    task write_total_length(input logic [31:0] v);
        drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        total_len = v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task set_idle_mode(input int mode);
        case (mode)
            IDLE_SEND: begin send_pct = 56; recv_pct = 0;  end
            IDLE_RECV: begin send_pct = 0;  recv_pct = 56; end
            IDLE_BOTH: begin send_pct = 10; recv_pct = 10; end
            default:   begin send_pct = 0;  recv_pct = 0;  end
        endcase
    endtask

    task check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            fails++;
        end
    endtask

    // Compare each delivered word with the oldest expected one
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, m_data);
                fails++;
            end else begin
                want = decoded_q.pop_front();
                check_field("out_byte", want.out_byte, m_data.out_byte);
                check_field("byte_valid", 8'(want.byte_valid), 8'(m_data.byte_valid));
                check_field("last_of_run", 8'(want.last_of_run), 8'(m_data.last_of_run));
                check_field("stream_done", 8'(want.stream_done), 8'(m_data.stream_done));
                check_field("status", 8'(want.status), 8'(m_data.status));
            end
        end
    end

    // Zero length: every byte is dropped, source empty reports done
    task test_zero_length();
        write_total_length(32'd0);
        send_word(mk_word(8'hFF, 1'b0));
        send_word(mk_word(8'h00, 1'b1));
    endtask

    // Literals, overlapping copies, the farthest offset and unwritten history
    task test_tokens();
        write_total_length(LEN_MAX);
        send_word(mk_word(8'h5F, 1'b0));
        send_word(mk_word(8'hA5, 1'b0));
        send_word(mk_word(8'h0F, 1'b0));
        send_word(mk_word(8'h00, 1'b0));
        send_word(mk_word(8'hFF, 1'b0));
        send_word(mk_word(8'hF0, 1'b0));
        send_word(mk_word(8'hFF, 1'b0));
        send_word(mk_word(8'h01, 1'b0));
        send_word(mk_word(8'h01, 1'b0));
        send_word(mk_word(8'h32, 1'b0));
        send_word(mk_word(8'h13, 1'b0));
        send_word(mk_word(8'h00, 1'b0));
        send_word(mk_word(8'h02, 1'b0));
        send_word(mk_word(8'h0F, 1'b0));
        send_word(mk_word(8'h14, 1'b0));
        send_word(mk_word(8'hFF, 1'b1));
    endtask

    // Length reached inside a copy: cut it short, then drop the next byte
    task test_length_cutoff();
        write_total_length(produced + 32'd5);
        send_word(mk_word(8'h80, 1'b0));
        send_word(mk_word(8'h0F, 1'b0));
        send_word(mk_word(8'h00, 1'b0));
        send_word(mk_word(8'h3C, 1'b0));
        send_word(mk_word(8'h00, 1'b1));
    endtask

    // Length lowered below what is already produced
    task test_length_below_produced();
        write_total_length(32'd1);
        send_word(mk_word(8'h7E, 1'b0));
        send_word(mk_word(8'h81, 1'b1));
    endtask

    // Random stream with some noise words, then a cut at a random nearby length
    task test_random_phase(input int mode, input int n_words);
        set_idle_mode(mode);
        write_total_length(LEN_MAX);
        repeat (n_words) send_word(next_word(6));
        write_total_length(produced + 32'($urandom_range(12, 1)));
        while (produced < total_len)
            send_word(next_word(0));
        send_word(mk_word(8'($urandom_range(255)), 1'b1));
    endtask

    // Receiver holds off long enough for the decoder to back up its input
    task test_backpressure();
        set_idle_mode(IDLE_NONE);
        write_total_length(LEN_MAX);
        hold_left = 400;
        repeat (40) send_word(next_word(0));
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_data = '0;
        for (int i = 0; i < WIN; i++)
            win_mem[i] = 8'h00;
        wr_pos = '0;
        produced = '0;
        total_len = '0;
        flag_bits = '0;
        flags_left = '0;
        tok_phase = PH_TOKEN;
        first_byte = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_zero_length();
        test_tokens();
        test_length_cutoff();
        test_length_below_produced();
        test_random_phase(IDLE_NONE, 60);
        test_random_phase(IDLE_SEND, 60);
        test_random_phase(IDLE_RECV, 60);
        test_random_phase(IDLE_BOTH, 60);
        test_backpressure();

        @(negedge aclk);
        s_valid <= 1'b0;
        drain_results();
        if (fails == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
